// ===== hdl/sld_pkg.sv =====
// Shared types and constants for the SCSI LUN decoder.
`default_nettype none
package sld_pkg;

    localparam int SLD_QUEUE_DEPTH = 2;
    localparam int LUN_W           = 64;
    localparam int UNIT_W          = 56;
    localparam int RES_DATA_W      = 80;

    // result forms
    localparam logic [2:0] FORM_PERIPH   = 3'd0;
    localparam logic [2:0] FORM_FLAT     = 3'd1;
    localparam logic [2:0] FORM_LOGICAL  = 3'd2;
    localparam logic [2:0] FORM_WELL_KN  = 3'd3;
    localparam logic [2:0] FORM_EXT_FLAT = 3'd4;
    localparam logic [2:0] FORM_EXT_NS   = 3'd5;
    localparam logic [2:0] FORM_EXT_OTH  = 3'd6;
    localparam logic [2:0] FORM_ALL_ONES = 3'd7;

    // top two bits of a level's first byte
    localparam logic [1:0] METH_PERIPH  = 2'd0;
    localparam logic [1:0] METH_FLAT    = 2'd1;
    localparam logic [1:0] METH_LOGICAL = 2'd2;
    localparam logic [1:0] METH_EXT     = 2'd3;

    // extended length codes and methods
    localparam logic [1:0] ELEN_1 = 2'd0;
    localparam logic [1:0] ELEN_3 = 2'd1;
    localparam logic [1:0] ELEN_5 = 2'd2;
    localparam logic [1:0] ELEN_7 = 2'd3;
    localparam logic [3:0] EMETH_WELL_KN = 4'h1;
    localparam logic [3:0] EMETH_FLAT    = 4'h2;
    localparam logic [3:0] EMETH_NS      = 4'hf;

    localparam logic [1:0] LAST_LEVEL = 2'd3;

    typedef struct packed {
        logic [LUN_W-1:0] word;
        logic             all_ones;
    } t_item;

    typedef struct packed {
        logic              trailing_data;
        logic [3:0]        ext_method;
        logic [1:0]        ext_length;
        logic [UNIT_W-1:0] unit_value;
        logic [5:0]        target_number;
        logic [5:0]        bus_number;
        logic [2:0]        form;
        logic [1:0]        level;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/sld_front.sv =====
// Front stage: accepts LUN words and tags the all-ones case.
`default_nettype none
module sld_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [63:0]           i_word,
    output logic                       o_push_valid,
    input  wire logic                  i_push_ready,
    output sld_pkg::t_item             o_push_item
);
    import sld_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready      = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.word     <= i_word;
            r_item.all_ones <= &i_word;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sld_queue.sv =====
// Short register queue between front and back stages.
`default_nettype none
module sld_queue #(
    parameter int DEPTH = sld_pkg::SLD_QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  sld_pkg::t_item      i_push_item,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output sld_pkg::t_item      o_pop_item
);
    import sld_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != CNT_MAX);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_MAX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_MAX) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sld_back.sv =====
// Back stage: walks a LUN's levels, one result per cycle unless stalled.
`default_nettype none
module sld_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_item_valid,
    output logic                o_item_ready,
    input  sld_pkg::t_item      i_item,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output sld_pkg::t_result    o_res,
    output logic                o_res_last
);
    import sld_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state           r_state;
    logic [LUN_W-1:0] r_word;     // current level's byte 0 in the top byte
    logic [1:0]       r_level;
    logic             r_ones;
    logic             r_res_valid;
    t_result          r_res;
    logic             r_res_last;

    t_result    n_res;
    logic       n_last;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       step;

    assign b0 = r_word[63:56];
    assign b1 = r_word[55:48];
    assign o_item_ready = (r_state == ST_IDLE);
    assign step = (r_state == ST_RUN) && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_res_last  = r_res_last;

    always_comb begin
        n_res       = '0;
        n_res.level = r_level;
        n_last      = 1'b1;
        if (r_ones) begin
            n_res.form = FORM_ALL_ONES;
        end else begin
            case (b0[7:6])
                METH_PERIPH: begin
                    n_res.form       = FORM_PERIPH;
                    n_res.bus_number = b0[5:0];
                    if (b0[5:0] == 6'd0) begin
                        n_res.unit_value = {48'd0, b1};
                    end else begin
                        n_res.target_number = b1[5:0];
                        n_last = (r_level == LAST_LEVEL);
                    end
                end
                METH_FLAT: begin
                    n_res.form       = FORM_FLAT;
                    n_res.unit_value = {42'd0, b0[5:0], b1};
                end
                METH_LOGICAL: begin
                    n_res.form          = FORM_LOGICAL;
                    n_res.target_number = b0[5:0];
                    n_res.bus_number    = {3'd0, b1[7:5]};
                    n_res.unit_value    = {51'd0, b1[4:0]};
                    // bytes past the LUN were shifted in as zero
                    n_res.trailing_data = (r_level != LAST_LEVEL) && (r_word[47:32] != 16'd0);
                end
                default: begin
                    n_res.ext_length = b0[5:4];
                    n_res.ext_method = b0[3:0];
                    if (b0[5:4] == ELEN_1 && b0[3:0] == EMETH_WELL_KN) begin
                        n_res.form       = FORM_WELL_KN;
                        n_res.unit_value = {48'd0, b1};
                    end else if (b0[5:4] == ELEN_3 && b0[3:0] == EMETH_FLAT) begin
                        n_res.form       = FORM_EXT_FLAT;
                        n_res.unit_value = {32'd0, r_word[55:32]};
                    end else if (b0[5:4] == ELEN_7 && b0[3:0] == EMETH_NS) begin
                        n_res.form = FORM_EXT_NS;
                    end else begin
                        n_res.form = FORM_EXT_OTH;
                        case (b0[5:4])
                            ELEN_1:  n_res.unit_value = {48'd0, b1};
                            ELEN_3:  n_res.unit_value = {32'd0, r_word[55:32]};
                            ELEN_5:  n_res.unit_value = {16'd0, r_word[55:16]};
                            default: n_res.unit_value = r_word[55:0];
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (step && n_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (step) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_ready && i_item_valid) begin
            r_word  <= i_item.word;
            r_ones  <= i_item.all_ones;
            r_level <= '0;
        end else if (step) begin
            r_word  <= {r_word[47:0], 16'd0};
            r_level <= r_level + 1'b1;
        end
        if (step) begin
            r_res      <= n_res;
            r_res_last <= n_last;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/scsi_lun_decoder_core.sv =====
// Top level of the SCSI LUN decoder: front stage, queue and level sequencer.
//
//  channel  dir  tdata                        tlast
//  s_axis   in   lun_word[63:0]               -
//  m_axis   out  one level result, 80 bits    last result of the LUN
//
// Sequencing: a LUN gives 1 to 4 results. The back sequencer loads a queued
// LUN while idle, then gives one result per level, holding while m_axis
// stalls; it takes no new LUN until it has produced the current one's last.
// Reset: synchronous, active low; clears valid flags, queue pointers, state.
// Stalls: the front keeps taking LUNs while the queue has room, even when
// m_axis is held off; the result register holds until its transfer.
`default_nettype none
module scsi_lun_decoder_core #(
    parameter int QUEUE_DEPTH = sld_pkg::SLD_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // [63:0] lun_word
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [1:0] level, [4:2] form, [10:5] bus_number, [16:11] target_number,
    // [72:17] unit_value, [74:73] ext_length, [78:75] ext_method,
    // [79] trailing_data
    output logic [79:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast    // last
);
    import sld_pkg::*;

    logic    push_valid;
    logic    push_ready;
    t_item   push_item;
    logic    pop_valid;
    logic    pop_ready;
    t_item   pop_item;
    t_result res;

    sld_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_word       (i_s_axis_tdata),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    sld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    sld_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (pop_valid),
        .o_item_ready (pop_ready),
        .i_item       (pop_item),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res        (res),
        .o_res_last   (o_m_axis_tlast)
    );

    // struct is declared low field last, so it packs straight into tdata
    assign o_m_axis_tdata = RES_DATA_W'(res);

endmodule
`default_nettype wire

// ===== hdl/sld_checker.sv =====
// Port-level assertions for the SCSI LUN decoder, bound to the top level.
`default_nettype none
module sld_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [79:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tlast
);
    import sld_pkg::*;

    logic [1:0] r_exp_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_level <= '0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_exp_level <= o_m_axis_tlast ? 2'd0 : o_m_axis_tdata[1:0] + 1'b1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    a_level_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[1:0] == r_exp_level)
        else $error("result level out of sequence");

    a_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[4:2] == FORM_ALL_ONES |->
            o_m_axis_tlast && o_m_axis_tdata[1:0] == 2'd0)
        else $error("all-ones result not single");

    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |->
            o_m_axis_tdata[4:2] == FORM_PERIPH && o_m_axis_tdata[10:5] != 6'd0)
        else $error("non-final result not peripheral with bus");

    a_trail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[79] |->
            o_m_axis_tdata[4:2] == FORM_LOGICAL && o_m_axis_tdata[1:0] != LAST_LEVEL)
        else $error("trailing flag on wrong form");

endmodule

bind scsi_lun_decoder_core sld_checker u_sld_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire

// ===== sim/lun_result_checker.sv =====
// Checker for the SCSI LUN decoder: predicts level results from LUN transfers and compares.
module lun_result_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,    // [63:0] lun_word
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [79:0] i_m_axis_tdata,    // [1:0] level .. [79] trailing_data
    input  wire logic        i_m_axis_tlast,    // last
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sld_pkg::*;

    typedef struct packed {
        logic    last;
        t_result res;
    } t_level_result;

    t_level_result expected_levels[$];
    int            mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // bytes past the eighth read as zero
    function automatic logic [7:0] lun_byte_at(input logic [63:0] w, input int idx);
        if (idx >= 8) return 8'h00;
        return w[8*(7-idx) +: 8];
    endfunction

    // big-endian value of nbytes LUN bytes from idx on
    function automatic logic [UNIT_W-1:0] lun_value(input logic [63:0] w, input int idx,
                                                   input int nbytes);
        logic [63:0] v;
        v = '0;
        for (int j = 0; j < nbytes; j++) v = {v[55:0], lun_byte_at(w, idx + j)};
        return v[UNIT_W-1:0];
    endfunction

    // Walks the LUN level by level and queues one expected result per level.
    function automatic void decode_lun_levels(input logic [63:0] w);
        t_level_result lr;
        logic [7:0]    b0;
        logic [7:0]    b1;
        logic          more;
        if (w == '1) begin
            lr          = '0;
            lr.res.form = FORM_ALL_ONES;
            lr.last     = 1'b1;
            expected_levels.push_back(lr);
            return;
        end
        for (int k = 0; k < 4; k++) begin
            b0           = lun_byte_at(w, 2*k);
            b1           = lun_byte_at(w, 2*k + 1);
            lr           = '0;
            more         = 1'b0;
            lr.res.level = 2'(k);
            case (b0[7:6])
                METH_PERIPH: begin
                    lr.res.form       = FORM_PERIPH;
                    lr.res.bus_number = b0[5:0];
                    if (b0[5:0] == 6'd0) begin
                        lr.res.unit_value = UNIT_W'(b1);
                    end else begin
                        // target byte is 8 bits, only the low six are kept
                        lr.res.target_number = b1[5:0];
                        more                 = 1'b1;
                    end
                end
                METH_FLAT: begin
                    lr.res.form       = FORM_FLAT;
                    lr.res.unit_value = UNIT_W'({b0[5:0], b1});
                end
                METH_LOGICAL: begin
                    lr.res.form          = FORM_LOGICAL;
                    lr.res.target_number = b0[5:0];
                    lr.res.bus_number    = 6'(b1[7:5]);
                    lr.res.unit_value    = UNIT_W'(b1[4:0]);
                    if (k < 3 && (lun_byte_at(w, 2*k + 2) | lun_byte_at(w, 2*k + 3)) != 8'h00)
                        lr.res.trailing_data = 1'b1;
                end
                default: begin
                    // extended addressing
                    lr.res.ext_length = b0[5:4];
                    lr.res.ext_method = b0[3:0];
                    if (b0[5:4] == ELEN_1 && b0[3:0] == EMETH_WELL_KN) begin
                        lr.res.form       = FORM_WELL_KN;
                        lr.res.unit_value = UNIT_W'(b1);
                    end else if (b0[5:4] == ELEN_3 && b0[3:0] == EMETH_FLAT) begin
                        lr.res.form       = FORM_EXT_FLAT;
                        lr.res.unit_value = lun_value(w, 2*k + 1, 3);
                    end else if (b0[5:4] == ELEN_7 && b0[3:0] == EMETH_NS) begin
                        lr.res.form = FORM_EXT_NS;
                    end else begin
                        // length code n carries 2n+1 value bytes
                        lr.res.form       = FORM_EXT_OTH;
                        lr.res.unit_value = lun_value(w, 2*k + 1, 2*int'(b0[5:4]) + 1);
                    end
                end
            endcase
            lr.last = !more || k == 3;
            expected_levels.push_back(lr);
            if (lr.last) break;
        end
    endfunction

    always @(posedge i_clk) begin
        t_level_result got;
        t_level_result want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready) decode_lun_levels(i_s_axis_tdata);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = {i_m_axis_tlast, i_m_axis_tdata};
                if (expected_levels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected level result: level=%0d form=%0d last=%0b",
                                 got.res.level, got.res.form, got.last);
                end else begin
                    want = expected_levels.pop_front();
                    if (got.res.level !== want.res.level || got.res.form !== want.res.form ||
                        got.res.bus_number !== want.res.bus_number ||
                        got.res.target_number !== want.res.target_number ||
                        got.res.unit_value !== want.res.unit_value ||
                        got.res.ext_length !== want.res.ext_length ||
                        got.res.ext_method !== want.res.ext_method ||
                        got.res.trailing_data !== want.res.trailing_data ||
                        got.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch exp: lvl=%0d form=%0d bus=%0d tgt=%0d unit=%h",
                                     want.res.level, want.res.form, want.res.bus_number,
                                     want.res.target_number, want.res.unit_value);
                            $display("    elen=%0d meth=%0d trail=%0b last=%0b",
                                     want.res.ext_length, want.res.ext_method,
                                     want.res.trailing_data, want.last);
                            $display("  got: lvl=%0d form=%0d bus=%0d tgt=%0d unit=%h",
                                     got.res.level, got.res.form, got.res.bus_number,
                                     got.res.target_number, got.res.unit_value);
                            $display("    elen=%0d meth=%0d trail=%0b last=%0b",
                                     got.res.ext_length, got.res.ext_method,
                                     got.res.trailing_data, got.last);
                        end
                    end
                end
            end
        end
        o_pending <= expected_levels.size();
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench top for the SCSI LUN decoder: reset, LUN stimulus, handshake idling and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [79:0] m_tdata;
    wire logic        m_tlast;
    int          fail_count;
    int          pending;

    // percent of cycles in which each side holds off
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // hand-picked LUNs: field extremes, every method, bytes past the eighth,
    // a full four-level peripheral chain, all-ones and its near miss
    localparam logic [63:0] DIRECTED_LUNS [25] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
        64'h00FF_0000_0000_0000, 64'h3FFF_01C0_2A55_3F80, 64'h7FFF_0000_0000_0000,
        64'h4000_0000_0000_0000, 64'hBFFF_0001_0000_0000, 64'h8000_0000_0000_0000,
        64'h0101_0203_BF12_0000, 64'h0101_0203_8012_0001, 64'h0101_0101_0101_BFFF,
        64'hC1FF_0000_0000_0000, 64'hD2AB_CDEF_0000_0000, 64'hC5A5_0000_0000_0000,
        64'hD712_3456_0000_0000, 64'hE3FE_DCBA_9876_0000, 64'hF0FF_FFFF_FFFF_FFFF,
        64'h0101_0203_F412_3456, 64'h0101_0101_0101_E9AB, 64'h0101_0101_0101_D2AB,
        64'h0105_00FF_0000_0000, 64'h0101_C1FF_0000_0000, 64'h0101_0101_3FFF_7FFF,
        64'h0101_FF00_0000_0000
    };

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    scsi_lun_decoder_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    lun_result_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tlast  (m_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // result side back-pressure
    always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Random gap, then hold the LUN until its transfer. tvalid is only
    // lowered inside a gap, so back-to-back LUNs keep it high.
    task automatic send_lun(input logic [63:0] lun);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lun;
        do @(posedge clk); while (!s_tready);
    endtask

    // Mostly well-formed multi-level LUNs with random content, some noise.
    function automatic logic [63:0] random_lun();
        logic [63:0] w;
        logic [7:0]  b0;
        int          pick;
        w    = {$urandom(), $urandom()};
        pick = $urandom_range(0, 99);
        if (pick < 3) return '1;
        if (pick < 20) return w;
        for (int k = 0; k < 4; k++) begin
            pick = $urandom_range(0, 10);
            case (pick)
                0, 1, 2, 3: b0 = {2'b00, 6'($urandom_range(1, 63))};  // peripheral, chains on
                4:          b0 = 8'h00;
                5:          b0 = {2'b01, 6'($urandom())};
                6:          b0 = {2'b10, 6'($urandom())};
                7:          b0 = 8'hC1;
                8:          b0 = 8'hD2;
                9:          b0 = 8'hFF;
                default:    b0 = {2'b11, 6'($urandom())};
            endcase
            w[63-16*k -: 8] = b0;
            if (pick > 3) begin
                // clean tail half the time so trailing bytes are sometimes zero
                if ($urandom_range(0, 1) == 1 && k < 3)
                    w = w & ~((64'd1 << (48 - 16*k)) - 64'd1);
                break;
            end
        end
        return w;
    endfunction

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver often stalled
        send_idle_pct = 26;
        recv_idle_pct = 67;
        foreach (DIRECTED_LUNS[i]) send_lun(DIRECTED_LUNS[i]);
        repeat (102) send_lun(random_lun());

        // sender sparse, receiver mostly ready
        send_idle_pct = 67;
        recv_idle_pct = 26;
        repeat (102) send_lun(random_lun());

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (102) send_lun(random_lun());
        s_tvalid <= 1'b0;

        // pending count is registered, so it trails the last transfer
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
